// ----- design/crc32s_pkg.sv -----
// Shared constants, types and CRC step functions for the CRC-32 stream engine.
`timescale 1ns / 1ps

package crc32s_pkg;

    localparam int unsigned CrcW   = 32;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned Lanes  = 4;
    localparam int unsigned CountW = 3;

    localparam logic [CrcW-1:0] CRC_POLY = 32'hEDB88320;
    localparam logic [CrcW-1:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [CountW-1:0] MAX_COUNT = CountW'(Lanes);

    // Control that travels with the lane sum into the merging stage
    typedef struct packed {
        logic              valid;
        logic [CountW-1:0] count;
        logic              start;
    } crc32s_ctl_t;

    // Reflected table entry for one byte index
    function automatic logic [CrcW-1:0] crc_table_entry(input logic [ByteW-1:0] idx);
        logic [CrcW-1:0] t;
        t = {{(CrcW-ByteW){1'b0}}, idx};
        for (int i = 0; i < ByteW; i++) begin
            t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
        end
        return t;
    endfunction

    // Fold one zero byte into a register value
    function automatic logic [CrcW-1:0] zero_step(input logic [CrcW-1:0] v);
        return crc_table_entry(v[ByteW-1:0]) ^ {{ByteW{1'b0}}, v[CrcW-1:ByteW]};
    endfunction

endpackage

// ----- design/crc32s_lane.sv -----
// One byte lane: carries its byte through the zero-byte steps that follow it.
`timescale 1ns / 1ps

module crc32s_lane (
    input  logic [crc32s_pkg::ByteW-1:0]  byte_in,
    input  logic [crc32s_pkg::CountW-1:0] steps,
    output logic [crc32s_pkg::CrcW-1:0]   contrib
);

    logic [crc32s_pkg::CrcW-1:0] z1;
    logic [crc32s_pkg::CrcW-1:0] z2;
    logic [crc32s_pkg::CrcW-1:0] z3;
    logic [crc32s_pkg::CrcW-1:0] z4;

    // Advance the byte through up to four table steps
    always_comb begin
        z1 = crc32s_pkg::crc_table_entry(byte_in);
        z2 = crc32s_pkg::zero_step(z1);
        z3 = crc32s_pkg::zero_step(z2);
        z4 = crc32s_pkg::zero_step(z3);
    end

    // Pick the step count; an unused lane gives nothing
    always_comb begin
        case (steps)
            3'd1:    contrib = z1;
            3'd2:    contrib = z2;
            3'd3:    contrib = z3;
            3'd4:    contrib = z4;
            default: contrib = '0;
        endcase
    end

endmodule

// ----- design/crc32s_merge.sv -----
// Merging stage: folds the lane sum into the running register and holds the result beat.
`timescale 1ns / 1ps

module crc32s_merge (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  crc32s_pkg::crc32s_ctl_t      ctl,
    input  logic [crc32s_pkg::CrcW-1:0]  lane_sum,
    output logic                         take,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [crc32s_pkg::CrcW-1:0]  m_running_value,
    output logic [crc32s_pkg::CrcW-1:0]  m_final_crc
);

    logic [crc32s_pkg::CrcW-1:0] crc_reg;
    logic [crc32s_pkg::CrcW-1:0] crc_next;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [crc32s_pkg::CrcW-1:0] base;
    logic [crc32s_pkg::CrcW-1:0] r1;
    logic [crc32s_pkg::CrcW-1:0] r2;
    logic [crc32s_pkg::CrcW-1:0] r3;
    logic [crc32s_pkg::CrcW-1:0] r4;
    logic [crc32s_pkg::CrcW-1:0] shifted;

    // Take a beat when the output register is empty or being drained
    assign take = ctl.valid && (!m_valid_reg || m_ready);

    // Register lane: advance the old value by the beat's byte count
    always_comb begin
        base = ctl.start ? crc32s_pkg::CRC_INIT : crc_reg;
        r1   = crc32s_pkg::zero_step(base);
        r2   = crc32s_pkg::zero_step(r1);
        r3   = crc32s_pkg::zero_step(r2);
        r4   = crc32s_pkg::zero_step(r3);
        case (ctl.count)
            3'd0:    shifted = base;
            3'd1:    shifted = r1;
            3'd2:    shifted = r2;
            3'd3:    shifted = r3;
            default: shifted = r4;
        endcase
    end

    // Merge lanes and hold the register while nothing is taken
    always_comb begin
        crc_next     = take ? (shifted ^ lane_sum) : crc_reg;
        m_valid_next = take || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg     <= crc32s_pkg::CRC_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            crc_reg     <= crc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_running_value = crc_reg;
    assign m_final_crc     = ~crc_reg;

endmodule

// ----- design/crc32_stream_engine.sv -----
// Top level of the reflected CRC-32 stream engine.
`timescale 1ns / 1ps

// Reflected CRC-32 (polynomial 0xEDB88320) over a byte stream of up to four bytes
// per beat, first byte in bits 7:0. s_start_msg reloads the register with all ones
// before the beat's bytes; a byte count of zero folds nothing in, counts above four
// are taken as four. Every input beat yields one result beat carrying the raw
// register and its complement, the finished CRC. One beat per cycle is sustained
// while m_ready stays high; four byte lanes first work out each byte's share into a
// register, then the merging stage advances the running register by the byte count
// and XORs the lane shares in, which is the feedback loop.
module crc32_stream_engine (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [crc32s_pkg::CrcW-1:0]  s_data_word,
    input  logic [crc32s_pkg::CountW-1:0] s_byte_count,
    input  logic                         s_start_msg,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [crc32s_pkg::CrcW-1:0]  m_running_value,
    output logic [crc32s_pkg::CrcW-1:0]  m_final_crc
);

    logic [crc32s_pkg::CountW-1:0] count_sat;
    logic [crc32s_pkg::CrcW-1:0]   contrib [crc32s_pkg::Lanes];
    logic [crc32s_pkg::CrcW-1:0]   lane_sum;
    logic [crc32s_pkg::CrcW-1:0]   lane_sum_reg;
    logic [crc32s_pkg::CrcW-1:0]   lane_sum_next;
    crc32s_pkg::crc32s_ctl_t       ctl_reg;
    crc32s_pkg::crc32s_ctl_t       ctl_next;
    logic                          take;
    logic                          s_fire;

    // Clamp the byte count to the lane count
    assign count_sat = (s_byte_count > crc32s_pkg::MAX_COUNT) ? crc32s_pkg::MAX_COUNT
                                                               : s_byte_count;

    // One lane per byte; each byte passes through the steps that follow it
    for (genvar k = 0; k < crc32s_pkg::Lanes; k++) begin : g_lane
        logic [crc32s_pkg::CountW-1:0] steps;
        assign steps = (count_sat > crc32s_pkg::CountW'(k))
                     ? (count_sat - crc32s_pkg::CountW'(k)) : '0;
        crc32s_lane u_lane (
            .byte_in (s_data_word[k*crc32s_pkg::ByteW +: crc32s_pkg::ByteW]),
            .steps   (steps),
            .contrib (contrib[k])
        );
    end

    // XOR the lane shares together
    always_comb begin
        lane_sum = '0;
        for (int k = 0; k < crc32s_pkg::Lanes; k++) begin
            lane_sum = lane_sum ^ contrib[k];
        end
    end

    // Lane stage: accept when empty or when the merging stage takes the held beat
    assign s_ready = !ctl_reg.valid || take;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        ctl_next      = ctl_reg;
        lane_sum_next = lane_sum_reg;
        if (s_fire) begin
            ctl_next.valid = 1'b1;
            ctl_next.count = count_sat;
            ctl_next.start = s_start_msg;
            lane_sum_next  = lane_sum;
        end else if (take) begin
            ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        lane_sum_reg <= lane_sum_next;
    end

    crc32s_merge u_merge (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctl             (ctl_reg),
        .lane_sum        (lane_sum_reg),
        .take            (take),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_running_value (m_running_value),
        .m_final_crc     (m_final_crc)
    );

endmodule
